/* sv/nlv_pkg.sv */
// ----------------------------------------------------------------------------
// nlv_pkg
// Shared types, phase and class codes and character constants for the
// number literal validator.
// ----------------------------------------------------------------------------
`default_nettype none

package nlv_pkg;

    typedef logic [7:0] t_code;
    typedef logic [1:0] t_phase;
    typedef logic [2:0] t_class;

    // scan phases
    localparam t_phase PH_LEAD  = 2'd0;
    localparam t_phase PH_BODY  = 2'd1;
    localparam t_phase PH_TRAIL = 2'd2;

    // class of the last non-space character
    localparam t_class CL_NONE  = 3'd0;
    localparam t_class CL_DIGIT = 3'd1;
    localparam t_class CL_EXP   = 3'd2;
    localparam t_class CL_POINT = 3'd3;
    localparam t_class CL_SIGN  = 3'd4;
    localparam t_class CL_MINUS = 3'd5;
    localparam t_class CL_OTHER = 3'd6;

    // character codes
    localparam t_code CH_SPACE = 8'h20;
    localparam t_code CH_EXP   = 8'h65;
    localparam t_code CH_POINT = 8'h2E;
    localparam t_code CH_PLUS  = 8'h2B;
    localparam t_code CH_MINUS = 8'h2D;
    localparam t_code CH_ZERO  = 8'h30;
    localparam t_code CH_NINE  = 8'h39;

    // one registered item handed to the scanner
    typedef struct packed {
        logic  en;
        t_code char_code;
        logic  is_last;
    } t_scan_in;

    // verdict from the scanner
    typedef struct packed {
        logic fire;
        logic is_valid;
    } t_scan_out;

endpackage

`default_nettype wire

/* sv/nlv_if.sv */
// ----------------------------------------------------------------------------
// nlv_char_if / nlv_res_if
// Valid/ready channels for character items and verdict items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlv_char_if
    import nlv_pkg::*;
;
    logic  valid;
    logic  ready;
    t_code char_code;
    logic  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface nlv_res_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

/* sv/nlv_scan.sv */
// ----------------------------------------------------------------------------
// nlv_scan
// Scan state of the validator: applies one character per enabled cycle and
// gives the verdict on the last character, then returns to the start state.
// ----------------------------------------------------------------------------
`default_nettype none

module nlv_scan
    import nlv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_scan_in  i_step,
    output t_scan_out      o_res
);

    t_phase r_phase, n_phase;
    t_class r_prev,  n_prev;
    logic   r_rej,   n_rej;
    logic   r_exp,   n_exp;
    logic   r_pnt,   n_pnt;

    // next state for one character
    always_comb begin
        logic first;
        logic digit;
        n_phase = r_phase;
        n_prev  = r_prev;
        n_rej   = r_rej;
        n_exp   = r_exp;
        n_pnt   = r_pnt;
        first   = (r_phase == PH_LEAD);
        digit   = (i_step.char_code >= CH_ZERO) && (i_step.char_code <= CH_NINE);

        if (i_step.char_code == CH_SPACE) begin
            if (r_phase != PH_LEAD) begin
                n_phase = PH_TRAIL;
            end
        end else begin
            // interior space
            if (r_phase == PH_TRAIL) begin
                n_rej = 1'b1;
            end
            // sign must be followed by digit or point
            if (r_prev == CL_SIGN && !digit && i_step.char_code != CH_POINT) begin
                n_rej = 1'b1;
            end
            priority if (digit) begin
                n_prev = CL_DIGIT;
            end else if (i_step.char_code == CH_EXP) begin
                if (r_exp || first || r_prev == CL_POINT) begin
                    n_rej = 1'b1;
                end
                n_exp  = 1'b1;
                n_prev = CL_EXP;
            end else if (i_step.char_code == CH_POINT) begin
                if (r_pnt || r_exp) begin
                    n_rej = 1'b1;
                end
                n_pnt  = 1'b1;
                n_prev = CL_POINT;
            end else if (i_step.char_code == CH_PLUS || i_step.char_code == CH_MINUS) begin
                priority if (first) begin
                    n_prev = CL_SIGN;
                end else if (i_step.char_code == CH_MINUS && r_prev == CL_EXP) begin
                    n_prev = CL_MINUS;
                end else begin
                    n_rej  = 1'b1;
                    n_prev = CL_OTHER;
                end
            end else begin
                n_rej  = 1'b1;
                n_prev = CL_OTHER;
            end
            n_phase = PH_BODY;
        end
    end

    // verdict on the last character
    assign o_res.fire     = i_step.en && i_step.is_last;
    assign o_res.is_valid = !n_rej && (n_phase != PH_LEAD)
                            && (n_prev != CL_POINT) && (n_prev != CL_SIGN);

    // state registers, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res.fire) begin
            r_phase <= PH_LEAD;
            r_prev  <= CL_NONE;
            r_rej   <= 1'b0;
            r_exp   <= 1'b0;
            r_pnt   <= 1'b0;
        end else if (i_step.en) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_rej   <= n_rej;
            r_exp   <= n_exp;
            r_pnt   <= n_pnt;
        end
    end

endmodule

`default_nettype wire

/* sv/number_literal_validator.sv */
// ----------------------------------------------------------------------------
// number_literal_validator
// Checks a character stream, one character per item, and gives one verdict
// item per string on its last character.
//
//   channel  dir  payload              note
//   i_char   in   char_code, is_last   one character per item
//   o_res    out  is_valid             one item per string, on is_last
//
// One character per cycle sustained while the result is not stalled; a
// character is held in the input register, and the scan works from the
// input register straight into the result register, which holds the verdict.
// The scan state update is the loop closed through the scan state registers.
// Reset is synchronous and active low; the scanner returns to its start
// state after each last character. A stalled result holds the pipeline;
// the input register still takes an item while the result waits, if it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module number_literal_validator
    import nlv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nlv_char_if.sink   i_char,
    nlv_res_if.source  o_res
);

    logic      r_in_vld;
    t_code     r_in_code;
    logic      r_in_last;
    logic      r_out_vld;
    logic      r_out_ok;
    logic      w_adv;
    t_scan_in  s_step;
    t_scan_out s_res;

    // pipeline advances when the result register is free or being emptied
    assign w_adv        = !r_out_vld || o_res.ready;
    assign i_char.ready = !r_in_vld || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_code <= i_char.char_code;
            r_in_last <= i_char.is_last;
        end
    end

    // scan state and verdict
    assign s_step.en        = r_in_vld && w_adv;
    assign s_step.char_code = r_in_code;
    assign s_step.is_last   = r_in_last;

    nlv_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_step),
        .o_res   (s_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_res.fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res.fire) begin
            r_out_ok <= s_res.is_valid;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.is_valid = r_out_ok;

`ifndef NO_ASSERTIONS
    // a verdict lands in the result register the next cycle
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.fire |=> r_out_vld && (r_out_ok == $past(s_res.is_valid)))
        else $error("verdict not captured in result register");

    // a held input item is kept while the pipeline is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld && $stable(r_in_code) && $stable(r_in_last))
        else $error("stalled input item lost");

    // reset empties both registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for number_literal_validator. Strings are split into character
// items and sent with random gaps on the input; the verdicts are taken with
// random stalls and checked in order against a scanner model kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import nlv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_code code;
        logic  last;
    } t_char_item;

    logic i_clk;
    logic i_rst_n;

    nlv_char_if ch ();
    nlv_res_if  res ();

    number_literal_validator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (ch),
        .o_res   (res)
    );

    // characters waiting to be sent, verdicts waiting to arrive
    t_char_item pending_chars[$];
    logic       verdict_q[$];
    t_code      word_buf[$];

    int total_chars;
    int accepted_chars;
    int error_cnt;

    // scanner model state
    t_phase scan_phase;
    logic   rejected;
    logic   exp_seen;
    logic   point_seen;
    t_class prev_class;

    // clock and reset
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        ch.valid = 1'b0;
        ch.char_code = '0;
        ch.is_last = 1'b0;
        res.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("[%0t] mismatch: %s, expected %b got %b", $realtime, what, want, got);
        error_cnt++;
    endtask

    task automatic clear_scan();
        scan_phase = PH_LEAD;
        rejected   = 1'b0;
        exp_seen   = 1'b0;
        point_seen = 1'b0;
        prev_class = CL_NONE;
    endtask

    // advance the scanner by one character, queue a verdict on the last one
    task automatic scan_char(input t_code c, input logic last);
        logic   first_ch;
        logic   is_digit;
        logic   ok;
        t_class cls;
        if (c == CH_SPACE) begin
            if (scan_phase != PH_LEAD)
                scan_phase = PH_TRAIL;
        end else begin
            if (scan_phase == PH_TRAIL)
                rejected = 1'b1;
            first_ch = (scan_phase == PH_LEAD);
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (prev_class == CL_SIGN && !is_digit && c != CH_POINT)
                rejected = 1'b1;
            if (is_digit) begin
                cls = CL_DIGIT;
            end else if (c == CH_EXP) begin
                if (exp_seen || first_ch || prev_class == CL_POINT)
                    rejected = 1'b1;
                exp_seen = 1'b1;
                cls = CL_EXP;
            end else if (c == CH_POINT) begin
                if (point_seen || exp_seen)
                    rejected = 1'b1;
                point_seen = 1'b1;
                cls = CL_POINT;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                if (first_ch) begin
                    cls = CL_SIGN;
                end else if (c == CH_MINUS && prev_class == CL_EXP) begin
                    cls = CL_MINUS;
                end else begin
                    rejected = 1'b1;
                    cls = CL_OTHER;
                end
            end else begin
                rejected = 1'b1;
                cls = CL_OTHER;
            end
            scan_phase = PH_BODY;
            prev_class = cls;
        end
        if (last) begin
            ok = !rejected && scan_phase != PH_LEAD
                && prev_class != CL_POINT && prev_class != CL_SIGN;
            verdict_q.push_back(ok);
            clear_scan();
        end
    endtask

    // move the word buffer into the send queue, last flag on its final byte
    task automatic flush_word();
        t_char_item it;
        foreach (word_buf[i]) begin
            it.code = word_buf[i];
            it.last = (i == word_buf.size() - 1);
            pending_chars.push_back(it);
        end
        total_chars += word_buf.size();
        word_buf.delete();
    endtask

    task automatic text_word(input string s);
        for (int i = 0; i < s.len(); i++)
            word_buf.push_back(t_code'(s[i]));
        flush_word();
    endtask

    function automatic t_code rand_digit();
        return t_code'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic t_code pick_special();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_EXP;
            2: return CH_POINT;
            3: return CH_PLUS;
            4: return CH_MINUS;
            5, 6: return rand_digit();
            default: return t_code'($urandom_range(0, 255));
        endcase
    endfunction

    // well-formed number with random content
    task automatic make_number();
        int n;
        repeat ($urandom_range(0, 2)) word_buf.push_back(CH_SPACE);
        if ($urandom_range(0, 2) == 0)
            word_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        n = $urandom_range(0, 3);
        repeat ($urandom_range(1, 4)) word_buf.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
            word_buf.push_back(CH_POINT);
            repeat ($urandom_range(1, 3)) word_buf.push_back(rand_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
            word_buf.push_back(CH_EXP);
            if ($urandom_range(0, 1))
                word_buf.push_back(CH_MINUS);
            repeat ($urandom_range(1, 3)) word_buf.push_back(rand_digit());
        end
        repeat (n == 3 ? 2 : 0) word_buf.push_back(CH_SPACE);
    endtask

    // one random edit: replace, insert or delete
    task automatic mutate_word();
        int pos;
        pos = $urandom_range(0, word_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: word_buf[pos] = pick_special();
            1: word_buf.insert(pos, pick_special());
            default: begin
                if (word_buf.size() > 1)
                    word_buf.delete(pos);
                else
                    word_buf[pos] = pick_special();
            end
        endcase
    endtask

    // stimulus
    initial begin
        int kind;
        total_chars = 0;
        accepted_chars = 0;
        error_cnt = 0;
        clear_scan();

        // directed strings
        text_word("0");
        text_word("9");
        text_word("  ");
        text_word(" ");
        text_word("+");
        text_word("- 1");
        text_word("1.");
        text_word(".5");
        text_word("1e-3");
        text_word("1-2");
        text_word("e1");
        text_word("1.e2");
        text_word("+.5 ");
        word_buf.push_back(8'h00);
        flush_word();
        word_buf.push_back(8'hFF);
        flush_word();

        // random strings
        while (total_chars < 570) begin
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                make_number();
            end else if (kind < 16) begin
                make_number();
                mutate_word();
            end else if (kind < 18) begin
                repeat ($urandom_range(1, 6)) word_buf.push_back(pick_special());
            end else begin
                repeat ($urandom_range(1, 4)) word_buf.push_back(t_code'($urandom_range(0, 255)));
            end
            flush_word();
        end

        // drain
        while (accepted_chars < total_chars) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_cnt == 0)
            $display("** number_literal_validator: PASSED **");
        else
            $display("** number_literal_validator: FAILED **");
        $finish;
    end

    // character driver with random gap bursts
    int  gap_left;
    int  drv_mood_left;
    logic drv_lazy;

    always @(posedge i_clk) begin
        t_char_item it;
        if (!i_rst_n) begin
            ch.valid <= 1'b0;
            gap_left = 0;
            drv_mood_left = 0;
            drv_lazy = 1'b0;
        end else begin
            if (ch.valid && ch.ready) begin
                scan_char(ch.char_code, ch.is_last);
                accepted_chars++;
            end
            if (drv_mood_left == 0) begin
                drv_mood_left = $urandom_range(20, 80);
                drv_lazy = $urandom_range(0, 2) != 0;
            end else begin
                drv_mood_left--;
            end
            if (!ch.valid || ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    ch.valid <= 1'b0;
                end else if (drv_lazy && pending_chars.size() > 40
                             && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 9) - 1;
                    ch.valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    it = pending_chars.pop_front();
                    ch.char_code <= it.code;
                    ch.is_last <= it.last;
                    ch.valid <= 1'b1;
                end else begin
                    ch.valid <= 1'b0;
                end
            end
        end
    end

    // verdict monitor with random stall bursts
    int  stall_left;
    int  mon_mood_left;
    logic mon_lazy;

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            stall_left = 0;
            mon_mood_left = 0;
            mon_lazy = 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none pending", 1'b0, res.is_valid);
                end else begin
                    want = verdict_q.pop_front();
                    if (res.is_valid !== want)
                        report_mismatch("is_valid", want, res.is_valid);
                end
            end
            if (mon_mood_left == 0) begin
                mon_mood_left = $urandom_range(20, 80);
                mon_lazy = $urandom_range(0, 2) != 0;
            end else begin
                mon_mood_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else if (mon_lazy && pending_chars.size() > 40
                         && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("** number_literal_validator: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
